@@ src/mer_pkg.sv @@
// Shared constants and types of the midpoint ellipse rasterizer.
// No dependencies; every module of the block imports this package.
package mer_pkg;

    localparam int RAD_BITS  = 10;                  // radius and point coordinate width
    localparam int CTR_BITS  = 10;                  // center coordinate width
    localparam int PIX_W     = 12;                  // emitted pixel coordinate width
    localparam int DEC_W     = 48;                  // decision value width (scaled by 4)
    localparam int SQ_W      = 2 * RAD_BITS;        // width of a radius squared
    localparam int HH_W      = 2 * (RAD_BITS + 1);  // width of (2x+1)^2 and (y-1)^2
    localparam int MUL_W     = 2 * RAD_BITS + 4;    // signed multiplier operand width
    localparam int PROD_W    = 2 * MUL_W;           // multiplier product width
    localparam int CFG_W     = (RAD_BITS > CTR_BITS) ? RAD_BITS : CTR_BITS;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_B = 2'd3;

    // mirror orders of the four symmetric pixels
    localparam logic MIR_REGION_ONE = 1'b0;  // (+x,+y) (-x,+y) (+x,-y) (-x,-y)
    localparam logic MIR_REGION_TWO = 1'b1;  // (+x,+y) (+x,-y) (-x,+y) (-x,-y)

    typedef struct packed {
        logic                valid;
        logic                mirror;
        logic                finished;
        logic [RAD_BITS-1:0] x;
        logic [RAD_BITS-1:0] y;
    } t_emit_req;

endpackage

@@ src/midpoint_ellipse_rasterizer_unit.sv @@
// Top level of the midpoint ellipse rasterizer: configuration registers, step sequencer
// around one shared multiplier. Depends on mer_pkg, mer_mul and mer_emit.
//
// Each accepted item either restarts the ellipse at (0, radius_b) or advances it by one
// midpoint step; every step that draws gives four mirror pixels, the fourth marked with
// last_of_step, and finished is set on all four once y reaches 0. After that, advance items
// give no pixels until the next restart. All products of the step (a^2, b^2, the region
// test and the decision updates) go one after another through a single registered signed
// multiplier. The four pixels of a step leave the output register one per cycle, as long
// as i_ready is high, while the next item is already being worked on; a step that draws
// holds in its last cycle until the emitter has taken all four pixels of the step before
// it.
module midpoint_ellipse_rasterizer_unit import mer_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_restart,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [PIX_W-1:0] o_pixel_x,
    output logic signed [PIX_W-1:0] o_pixel_y,
    output logic                    o_last_of_step,
    output logic                    o_finished,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    localparam int YW = RAD_BITS + 2;

    localparam logic signed [YW-1:0]       Y_ONE   = YW'(1);
    localparam logic signed [YW-1:0]       Y_TWO   = YW'(2);
    localparam logic signed [YW-1:0]       Y_THREE = YW'(3);
    localparam logic signed [RAD_BITS:0]   YM_ONE  = (RAD_BITS + 1)'(1);
    localparam logic        [RAD_BITS+1:0] X_TWO   = (RAD_BITS + 2)'(2);
    localparam logic        [RAD_BITS+1:0] X_THREE = (RAD_BITS + 2)'(3);

    typedef enum logic [4:0] {
        S_IDLE, S_SQA, S_SQB, S_DISP, S_RST,
        S_L1, S_L2, S_CMP, S_T0, S_T1, S_T2,
        S_H0, S_H1, S_H2, S_H3, S_H4, S_H5,
        S_P2, S_Q1, S_Q2, S_EMIT
    } t_state;

    t_state                    r_state;
    logic [CTR_BITS-1:0]       r_center_x;
    logic [CTR_BITS-1:0]       r_center_y;
    logic [RAD_BITS-1:0]       r_radius_a;
    logic [RAD_BITS-1:0]       r_radius_b;
    logic [RAD_BITS-1:0]       r_px;
    logic [RAD_BITS-1:0]       r_py;
    logic [DEC_W-1:0]          r_dec;
    logic                      r_region_two;
    logic                      r_done;
    logic                      r_restart;
    logic                      r_neg;
    logic                      r_mirror;
    logic [SQ_W-1:0]           r_a2;
    logic [SQ_W-1:0]           r_b2;
    logic signed [DEC_W-1:0]   r_tmp;

    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [DEC_W-1:0]   prod;
    logic [DEC_W-1:0]          prod4;
    logic [RAD_BITS+1:0]       x2p2;
    logic [RAD_BITS+1:0]       x2p3;
    logic [RAD_BITS:0]         h;
    logic signed [YW-1:0]      y2;
    logic signed [YW-1:0]      y2m1;
    logic signed [YW-1:0]      two_m_y2;
    logic signed [YW-1:0]      three_m_y2;
    logic signed [RAD_BITS:0]  ym;
    logic [RAD_BITS-1:0]       py_dec;
    logic [RAD_BITS-1:0]       px_inc;
    logic                      emit_busy;
    t_emit_req                 emit_req;

    always_comb begin
        prod       = DEC_W'(mul_p);
        prod4      = {prod[DEC_W-3:0], 2'b00};
        x2p2       = {1'b0, r_px, 1'b0} + X_TWO;
        x2p3       = {1'b0, r_px, 1'b0} + X_THREE;
        h          = {r_px, 1'b1};
        y2         = $signed({1'b0, r_py, 1'b0});
        y2m1       = y2 - Y_ONE;
        two_m_y2   = Y_TWO - y2;
        three_m_y2 = Y_THREE - y2;
        ym         = $signed({1'b0, r_py}) - YM_ONE;
        py_dec     = r_py - RAD_BITS'(1);
        px_inc     = r_px + RAD_BITS'(1);
    end

    // operand select of the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQA: begin
                mul_a = MUL_W'(r_radius_a);
                mul_b = MUL_W'(r_radius_a);
            end
            S_SQB: begin
                mul_a = MUL_W'(r_radius_b);
                mul_b = MUL_W'(r_radius_b);
            end
            S_DISP: begin
                mul_a = MUL_W'(r_a2);
                mul_b = MUL_W'(r_radius_b);
            end
            S_L1: begin
                mul_a = MUL_W'(r_a2);
                mul_b = MUL_W'(y2m1);
            end
            S_L2: begin
                mul_a = MUL_W'(r_b2);
                mul_b = MUL_W'(x2p2);
            end
            S_T0: begin
                mul_a = MUL_W'(r_b2);
                mul_b = MUL_W'(x2p3);
            end
            S_T1: begin
                mul_a = MUL_W'(r_a2);
                mul_b = MUL_W'(two_m_y2);
            end
            S_H0: begin
                mul_a = MUL_W'(h);
                mul_b = MUL_W'(h);
            end
            S_H1: begin
                mul_a = MUL_W'(r_b2);
                mul_b = MUL_W'(prod[HH_W-1:0]);
            end
            S_H2: begin
                mul_a = MUL_W'(ym);
                mul_b = MUL_W'(ym);
            end
            S_H3: begin
                mul_a = MUL_W'(r_a2);
                mul_b = MUL_W'(prod[HH_W-1:0]);
            end
            S_H4: begin
                mul_a = MUL_W'(r_a2);
                mul_b = MUL_W'(r_b2);
            end
            S_P2: begin
                mul_a = MUL_W'(r_a2);
                mul_b = MUL_W'(three_m_y2);
            end
            S_Q1: begin
                mul_a = MUL_W'(r_b2);
                mul_b = MUL_W'(x2p2);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    mer_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_center_x   <= '0;
            r_center_y   <= '0;
            r_radius_a   <= RAD_BITS'(1);
            r_radius_b   <= RAD_BITS'(1);
            r_px         <= '0;
            r_py         <= '0;
            r_dec        <= '0;
            r_region_two <= 1'b0;
            r_done       <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CENTER_X: r_center_x <= i_cfg_data[CTR_BITS-1:0];
                    CFG_CENTER_Y: r_center_y <= i_cfg_data[CTR_BITS-1:0];
                    CFG_RADIUS_A: r_radius_a <= i_cfg_data[RAD_BITS-1:0];
                    CFG_RADIUS_B: r_radius_b <= i_cfg_data[RAD_BITS-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_SQA;
                    end
                end
                S_SQA: r_state <= S_SQB;
                S_SQB: r_state <= S_DISP;
                S_DISP: begin
                    if (r_restart) begin
                        r_state <= S_RST;
                    end else if (r_done) begin
                        r_state <= S_IDLE;
                    end else if (r_region_two) begin
                        r_state <= S_P2;
                    end else begin
                        r_state <= S_L1;
                    end
                end
                S_RST: begin
                    r_dec        <= DEC_W'({r_b2, 2'b00}) + DEC_W'(r_a2) - prod4;
                    r_px         <= '0;
                    r_py         <= r_radius_b;
                    r_region_two <= 1'b0;
                    r_done       <= (r_radius_b == '0);
                    r_state      <= S_EMIT;
                end
                S_L1: r_state <= S_L2;
                S_L2: r_state <= S_CMP;
                S_CMP: begin
                    // region one continues while a^2(2y-1) > 2b^2(x+1)
                    r_state <= (r_tmp > prod) ? S_T0 : S_H0;
                end
                S_T0: r_state <= S_T1;
                S_T1: begin
                    r_dec <= r_dec + prod4;
                    if (r_neg) begin
                        r_px    <= px_inc;
                        r_done  <= (r_py == '0);
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_T2;
                    end
                end
                S_T2: begin
                    r_dec   <= r_dec + prod4;
                    r_px    <= px_inc;
                    r_py    <= py_dec;
                    r_done  <= (py_dec == '0);
                    r_state <= S_EMIT;
                end
                S_H0: r_state <= S_H1;
                S_H1: r_state <= S_H2;
                S_H2: begin
                    r_dec   <= prod;
                    r_state <= S_H3;
                end
                S_H3: r_state <= S_H4;
                S_H4: begin
                    r_dec   <= r_dec + prod4;
                    r_state <= S_H5;
                end
                S_H5: begin
                    r_dec        <= r_dec - prod4;
                    r_region_two <= 1'b1;
                    r_state      <= S_P2;
                end
                S_P2: begin
                    if (r_py == '0) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_Q1;
                    end
                end
                S_Q1: begin
                    r_dec <= r_dec + prod4;
                    if (r_neg) begin
                        r_state <= S_Q2;
                    end else begin
                        r_py    <= py_dec;
                        r_done  <= (py_dec == '0);
                        r_state <= S_EMIT;
                    end
                end
                S_Q2: begin
                    r_dec   <= r_dec + prod4;
                    r_px    <= px_inc;
                    r_py    <= py_dec;
                    r_done  <= (py_dec == '0);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // hold until the emitter has loaded the previous item's last pixel
                    if (!emit_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // working registers of the current item
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_restart <= i_restart;
        end
        if (r_state == S_SQB) begin
            r_a2 <= prod[SQ_W-1:0];
        end
        if (r_state == S_DISP) begin
            r_b2 <= prod[SQ_W-1:0];
        end
        if (r_state == S_L2) begin
            r_tmp <= prod;
        end
        if (r_state == S_CMP || r_state == S_P2) begin
            r_neg <= r_dec[DEC_W-1];
        end
        if (r_state == S_RST || r_state == S_T1 || r_state == S_T2) begin
            r_mirror <= MIR_REGION_ONE;
        end
        if (r_state == S_Q1 || r_state == S_Q2) begin
            r_mirror <= MIR_REGION_TWO;
        end
    end

    always_comb begin
        emit_req.valid    = (r_state == S_EMIT) && !emit_busy;
        emit_req.mirror   = r_mirror;
        emit_req.finished = r_done;
        emit_req.x        = r_px;
        emit_req.y        = r_py;
    end

    mer_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (emit_req),
        .i_center_x     (r_center_x),
        .i_center_y     (r_center_y),
        .o_busy         (emit_busy),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_last_of_step (o_last_of_step),
        .o_finished     (o_finished)
    );

    assign o_ready = (r_state == S_IDLE);

endmodule

@@ src/mer_mul.sv @@
// Shared signed multiplier of the ellipse rasterizer, product registered.
// Depends on mer_pkg for the operand and product widths.
module mer_mul import mer_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_p
);

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

@@ src/mer_emit.sv @@
// Pixel emitter: expands one point into its four mirror pixels, one per ready cycle
// through an output register. Depends on mer_pkg for widths and the request struct.
module mer_emit import mer_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_emit_req                  i_req,
    input  logic        [CTR_BITS-1:0] i_center_x,
    input  logic        [CTR_BITS-1:0] i_center_y,
    output logic                       o_busy,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [PIX_W-1:0]    o_pixel_x,
    output logic signed [PIX_W-1:0]    o_pixel_y,
    output logic                       o_last_of_step,
    output logic                       o_finished
);

    logic        [2:0]          r_cnt;
    logic        [1:0]          r_k;
    logic        [RAD_BITS-1:0] r_x;
    logic        [RAD_BITS-1:0] r_y;
    logic                       r_mirror;
    logic                       r_fin;
    logic                       r_valid;
    logic signed [PIX_W-1:0]    r_pix_x;
    logic signed [PIX_W-1:0]    r_pix_y;
    logic                       r_last;
    logic                       r_fin_out;

    logic                       load;
    logic                       neg_x;
    logic                       neg_y;
    logic        [PIX_W-1:0]    cx;
    logic        [PIX_W-1:0]    cy;
    logic        [PIX_W-1:0]    ox;
    logic        [PIX_W-1:0]    oy;
    logic        [PIX_W-1:0]    px;
    logic        [PIX_W-1:0]    py;

    assign load  = (r_cnt != 3'd0) && (!r_valid || i_ready);
    assign neg_x = (r_mirror == MIR_REGION_TWO) ? r_k[1] : r_k[0];
    assign neg_y = (r_mirror == MIR_REGION_TWO) ? r_k[0] : r_k[1];

    always_comb begin
        cx = PIX_W'(i_center_x);
        cy = PIX_W'(i_center_y);
        ox = PIX_W'(r_x);
        oy = PIX_W'(r_y);
        px = neg_x ? (cx - ox) : (cx + ox);
        py = neg_y ? (cy - oy) : (cy + oy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= 3'd0;
            r_k     <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (i_req.valid) begin
                r_cnt <= 3'd4;
                r_k   <= 2'd0;
            end else if (load) begin
                r_cnt <= r_cnt - 3'd1;
                r_k   <= r_k + 2'd1;
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_x      <= i_req.x;
            r_y      <= i_req.y;
            r_mirror <= i_req.mirror;
            r_fin    <= i_req.finished;
        end
        if (load) begin
            r_pix_x   <= $signed(px);
            r_pix_y   <= $signed(py);
            r_last    <= (r_k == 2'd3);
            r_fin_out <= r_fin;
        end
    end

    assign o_busy         = (r_cnt != 3'd0);
    assign o_valid        = r_valid;
    assign o_pixel_x      = r_pix_x;
    assign o_pixel_y      = r_pix_y;
    assign o_last_of_step = r_last;
    assign o_finished     = r_fin_out;

endmodule
